// ===== rtl/pob_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pob_pkg: shared types and constants of the phasor oscillator bank
// Entry layout of the oscillator store, control codes, Q1.15 rounding.
// ----------------------------------------------------------------------------
package pob_pkg;

  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int Q_W    = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 24;
  localparam int SMP_W  = 22;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic signed [ACC_W-1:0] SAMPLE_MAX = 24'sd2097151;
  localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -24'sd2097152;

  typedef struct packed {
    logic signed [Q_W-1:0] rot_cos;
    logic signed [Q_W-1:0] rot_sin;
    logic signed [Q_W-1:0] amplitude;
    logic signed [Q_W-1:0] ph_re;
    logic signed [Q_W-1:0] ph_im;
  } pob_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_OUT
  } pob_state_e;

  // round half up, then saturate to Q1.15
  function automatic logic signed [Q_W-1:0] round_sat_q15(input logic signed [PROD_W:0] v);
    logic signed [PROD_W+1:0] t;
    logic signed [18:0]       s;
    t = (PROD_W+2)'(v) + 34'sd16384;
    s = 19'(t >>> 15);
    if (s > 19'sd32767) begin
      return 16'sh7fff;
    end else if (s < -19'sd32768) begin
      return 16'sh8000;
    end
    return s[Q_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pob_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pob_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pob_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/phasor_oscillator_bank_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phasor_oscillator_bank_top: complex phasor additive oscillator bank
// Loads store one oscillator; ticks sum amp*imag over the active oscillators
// and rotate each one's phase, with read-modify-write on one entry RAM.
// ----------------------------------------------------------------------------
// Load item: taken only in idle, written to the RAM at acceptance.
// Tick item: sample valid once all N oscillators are read and written back,
//   N = min(active_count, OSCILLATORS); one oscillator read per cycle.
// Next item taken once the tick returns to idle, later while the
//   previous sample waits; a waiting sample does not block loads.
// Reset clears control state and active_count; RAM entries are undefined until loaded.
module phasor_oscillator_bank_top #(
  parameter int OSCILLATORS = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pob_pkg::CNT_W-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              mode_i,
  input  wire logic [pob_pkg::IDX_W-1:0]         osc_index_i,
  input  wire logic signed [pob_pkg::Q_W-1:0]    rot_cos_i,
  input  wire logic signed [pob_pkg::Q_W-1:0]    rot_sin_i,
  input  wire logic signed [pob_pkg::Q_W-1:0]    amplitude_i,
  input  wire logic signed [pob_pkg::Q_W-1:0]    start_real_i,
  input  wire logic signed [pob_pkg::Q_W-1:0]    start_imag_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [pob_pkg::SMP_W-1:0]       sample_o
);
  import pob_pkg::*;

  localparam int ADDR_W = (OSCILLATORS > 1) ? $clog2(OSCILLATORS) : 1;
  localparam int ENT_W  = $bits(pob_entry_t);

  pob_state_e state_q, state_d;
  logic [CNT_W-1:0] active_count_q;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rd_vld_q, mul_vld_q;
  logic [ADDR_W-1:0] rd_addr_q, mul_addr_q;
  logic             out_valid_q;
  logic signed [SMP_W-1:0] sample_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  logic signed [PROD_W-1:0] p_rc_q, p_is_q, p_rs_q, p_ic_q, p_ai_q;
  logic signed [Q_W-1:0]    mul_cos_q, mul_sin_q, mul_amp_q;

  logic rd_en, acc_clr, out_load, in_ready;
  logic tick_acc, load_acc, load_hit;
  logic [CNT_W-1:0] cnt_cap;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  pob_entry_t        ram_wdata, rd_entry, load_entry, wb_entry;
  logic [ENT_W-1:0]  ram_rdata;

  logic signed [PROD_W:0]  new_re, new_im;
  logic signed [16:0]      term;
  logic signed [SMP_W-1:0] sample_sat;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  assign tick_acc = in_valid_i && in_ready && (mode_i == MODE_TICK);
  assign load_acc = in_valid_i && in_ready && (mode_i == MODE_LOAD);
  assign load_hit = load_acc && (int'(osc_index_i) < OSCILLATORS);
  assign cnt_cap  = (int'(active_count_q) > OSCILLATORS) ? CNT_W'(OSCILLATORS)
                                                          : active_count_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    rd_en    = 1'b0;
    acc_clr  = 1'b0;
    out_load = 1'b0;
    in_ready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i && (mode_i == MODE_TICK)) begin
          state_d = S_RUN;
          idx_d   = '0;
          cnt_d   = cnt_cap;
          acc_clr = 1'b1;
        end
      end
      S_RUN: begin
        if (idx_q == cnt_q) begin
          state_d = S_DRAIN;
        end else begin
          rd_en = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_q && !mul_vld_q) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // stage 2: rotate, round, saturate, accumulate
  assign new_re = (PROD_W+1)'(p_rc_q) - (PROD_W+1)'(p_is_q);
  assign new_im = (PROD_W+1)'(p_rs_q) + (PROD_W+1)'(p_ic_q);
  assign term   = 17'(p_ai_q >>> 15);

  always_comb begin
    acc_d = acc_q;
    if (acc_clr) begin
      acc_d = '0;
    end else if (mul_vld_q) begin
      acc_d = acc_q + ACC_W'(term);
    end
  end

  always_comb begin
    if (acc_q > SAMPLE_MAX) begin
      sample_sat = SAMPLE_MAX[SMP_W-1:0];
    end else if (acc_q < SAMPLE_MIN) begin
      sample_sat = SAMPLE_MIN[SMP_W-1:0];
    end else begin
      sample_sat = acc_q[SMP_W-1:0];
    end
  end

  always_comb begin
    load_entry.rot_cos   = rot_cos_i;
    load_entry.rot_sin   = rot_sin_i;
    load_entry.amplitude = amplitude_i;
    load_entry.ph_re     = start_real_i;
    load_entry.ph_im     = start_imag_i;
    wb_entry.rot_cos     = mul_cos_q;
    wb_entry.rot_sin     = mul_sin_q;
    wb_entry.amplitude   = mul_amp_q;
    wb_entry.ph_re       = round_sat_q15(new_re);
    wb_entry.ph_im       = round_sat_q15(new_im);
  end

  // loads are taken only in idle, so they never meet a write-back
  assign ram_we    = mul_vld_q || load_hit;
  assign ram_waddr = mul_vld_q ? mul_addr_q : ADDR_W'(osc_index_i);
  assign ram_wdata = mul_vld_q ? wb_entry : load_entry;
  assign rd_entry  = pob_entry_t'(ram_rdata);

  pob_ram #(
    .WIDTH (ENT_W),
    .DEPTH (OSCILLATORS),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (ADDR_W'(idx_q)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      active_count_q <= '0;
      idx_q          <= '0;
      cnt_q          <= '0;
      rd_vld_q       <= 1'b0;
      mul_vld_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      acc_q          <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_en;
      mul_vld_q <= rd_vld_q;
      acc_q     <= acc_d;
      if (cfg_valid_i) begin
        active_count_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_addr_q <= ADDR_W'(idx_q);
    end
    if (rd_vld_q) begin
      mul_addr_q <= rd_addr_q;
      p_rc_q     <= $signed(rd_entry.ph_re) * $signed(rd_entry.rot_cos);
      p_is_q     <= $signed(rd_entry.ph_im) * $signed(rd_entry.rot_sin);
      p_rs_q     <= $signed(rd_entry.ph_re) * $signed(rd_entry.rot_sin);
      p_ic_q     <= $signed(rd_entry.ph_im) * $signed(rd_entry.rot_cos);
      p_ai_q     <= $signed(rd_entry.amplitude) * $signed(rd_entry.ph_im);
      mul_cos_q  <= rd_entry.rot_cos;
      mul_sin_q  <= rd_entry.rot_sin;
      mul_amp_q  <= rd_entry.amplitude;
    end
    if (out_load) begin
      sample_q <= sample_sat;
    end
  end

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!rd_vld_q && !mul_vld_q))
    else $error("item accepted with oscillator pipeline busy");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (idx_q <= cnt_q))
    else $error("oscillator index ran past count");

  a_out_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (!rd_vld_q && !mul_vld_q))
    else $error("sample issued before write-back finished");

  a_tick_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> (acc_q == '0) && (state_q == S_RUN))
    else $error("tick did not start with a cleared accumulator");

endmodule
`default_nettype wire
